// ----- design/iadc_pkg.sv -----
`timescale 1ns / 1ps

package iadc_pkg;

  // Sizing
  localparam int HASH_BITS   = 12;
  localparam int RANGE_DEPTH = 64;
  localparam int SLOT_AW     = HASH_BITS + 1;            // both lists share one table
  localparam int SLOTS       = 1 << SLOT_AW;
  localparam int CNT_W       = HASH_BITS + 1;            // per-list entry count
  localparam int SWEPT_W     = HASH_BITS + 2;            // slots freed by one sweep
  localparam int FILL_W      = $clog2(RANGE_DEPTH + 1);  // prefix fill per list

  // murmur3 finalizer multipliers
  localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;

  // Request codes
  localparam logic [3:0] OP_CHECK     = 4'd0;
  localparam logic [3:0] OP_ADD_ADDR  = 4'd1;
  localparam logic [3:0] OP_RM_ADDR   = 4'd2;
  localparam logic [3:0] OP_ADD_PFX   = 4'd3;
  localparam logic [3:0] OP_RM_PFX    = 4'd4;
  localparam logic [3:0] OP_SWEEP     = 4'd5;
  localparam logic [3:0] OP_CLR_SRC   = 4'd6;
  localparam logic [3:0] OP_STAT      = 4'd7;
  localparam logic [3:0] OP_CLEAR_ALL = 4'd8;

  // Verdict codes
  localparam logic [1:0] VERDICT_NEUTRAL = 2'd0;
  localparam logic [1:0] VERDICT_BYPASS  = 2'd1;
  localparam logic [1:0] VERDICT_DROP    = 2'd2;

  // Statistic selectors
  localparam logic [2:0] STAT_ALLOW_CNT  = 3'd0;
  localparam logic [2:0] STAT_DENY_CNT   = 3'd1;
  localparam logic [2:0] STAT_ALLOW_FILL = 3'd2;
  localparam logic [2:0] STAT_DENY_FILL  = 3'd3;
  localparam logic [2:0] STAT_ALLOW_HITS = 3'd4;
  localparam logic [2:0] STAT_DENY_HITS  = 3'd5;
  localparam logic [2:0] STAT_BYPASSES   = 3'd6;
  localparam logic [2:0] STAT_DROPS      = 3'd7;

  typedef struct packed {
    logic [3:0]  req_type;
    logic        list_sel;
    logic [31:0] address;
    logic [5:0]  mask_len;
    logic [31:0] expire_seconds;
    logic [1:0]  source_code;
    logic [31:0] now_time;
    logic [2:0]  stat_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        op_ok;
    logic [13:0] swept_count;
    logic [63:0] stat_value;
  } rsp_t;

  // One address table slot
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] deadline;
    logic        valid;
    logic [1:0]  src;
  } slot_t;

  // One prefix entry held by a cell
  typedef struct packed {
    logic [31:0] net;
    logic [5:0]  len;
    logic [31:0] deadline;
  } pfx_ent_t;

  // Query broadcast to every cell
  typedef struct packed {
    logic [31:0] addr;
    logic [5:0]  plen;
    logic [31:0] now;
    logic        exact_cmp;  // remove: equal network and raw length
  } pfx_query_t;

  typedef struct packed {
    logic add;
    logic del;
  } pfx_ctl_t;

  // Zero deadline never expires
  function automatic logic expired(input logic [31:0] deadline, input logic [31:0] now);
    return (deadline != 32'd0) && (deadline < now);
  endfunction

endpackage

// ----- design/iadc_ram.sv -----
`timescale 1ns / 1ps

module iadc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/iadc_hash.sv -----
`timescale 1ns / 1ps

// Two-stage murmur3 finalizer, one multiply per stage
module iadc_hash (
  input  logic                           clk,
  input  logic [31:0]                    addr,
  output logic [iadc_pkg::HASH_BITS-1:0] slot_idx
);

  logic [31:0] x1, x2, x3;
  logic [31:0] mix1_r, mix2_r;

  assign x1 = addr ^ (addr >> 16);
  assign x2 = mix1_r ^ (mix1_r >> 13);
  assign x3 = mix2_r ^ (mix2_r >> 16);

  always_ff @(posedge clk) begin
    mix1_r <= x1 * iadc_pkg::MIX_C1;
    mix2_r <= x2 * iadc_pkg::MIX_C2;
  end

  assign slot_idx = x3[iadc_pkg::HASH_BITS-1:0];

endmodule

// ----- design/iadc_cell.sv -----
`timescale 1ns / 1ps

// One prefix entry: local compare, load or take the upper neighbor's entry
module iadc_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  live,
  input  logic                  load_en,
  input  logic                  shift_en,
  input  iadc_pkg::pfx_ent_t    new_ent,
  input  iadc_pkg::pfx_ent_t    next_ent,
  input  iadc_pkg::pfx_query_t  query,
  output iadc_pkg::pfx_ent_t    ent,
  output logic                  hit
);

  iadc_pkg::pfx_ent_t ent_r, ent_nxt;
  logic               hit_r, hit_nxt;
  logic [31:0]        len_mask;
  logic               check_hit, exact_hit;

  // Network mask from stored length; 32 and above means exact
  assign len_mask  = (ent_r.len >= 6'd32) ? 32'hFFFF_FFFF
                                          : ~(32'hFFFF_FFFF >> ent_r.len[4:0]);
  assign check_hit = !iadc_pkg::expired(ent_r.deadline, query.now) &&
                     (((query.addr ^ ent_r.net) & len_mask) == 32'd0);
  assign exact_hit = (ent_r.net == query.addr) && (ent_r.len == query.plen);

  always_comb begin
    hit_nxt = live && (query.exact_cmp ? exact_hit : check_hit);
    if (shift_en) begin
      ent_nxt = next_ent;
    end else if (load_en) begin
      ent_nxt = new_ent;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign ent = ent_r;
  assign hit = hit_r;

endmodule

// ----- design/iadc_chain.sv -----
`timescale 1ns / 1ps

// Compacted prefix list of one list: a row of cells, removal closes the gap
module iadc_chain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iadc_pkg::pfx_ctl_t            ctl,
  input  logic [iadc_pkg::FILL_W-1:0]   fill,
  input  iadc_pkg::pfx_ent_t            new_ent,
  input  iadc_pkg::pfx_query_t          query,
  output logic                          any_hit
);

  localparam int N = iadc_pkg::RANGE_DEPTH;

  iadc_pkg::pfx_ent_t ent_vec [N];
  iadc_pkg::pfx_ent_t nbr_vec [N];
  logic [N-1:0]       hit_vec;
  logic [N-1:0]       first_seen;

  for (genvar k = 0; k < N; k++) begin : g_cell
    // Last cell has no upper neighbor
    if (k == N - 1) begin : g_top
      assign nbr_vec[k] = '0;
    end else begin : g_mid
      assign nbr_vec[k] = ent_vec[k+1];
    end

    // At or above the first match, every cell moves down one place
    assign first_seen[k] = |hit_vec[k:0];

    iadc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .live     (iadc_pkg::FILL_W'(k) < fill),
      .load_en  (ctl.add && (iadc_pkg::FILL_W'(k) == fill)),
      .shift_en (ctl.del && first_seen[k]),
      .new_ent  (new_ent),
      .next_ent (nbr_vec[k]),
      .query    (query),
      .ent      (ent_vec[k]),
      .hit      (hit_vec[k])
    );
  end

  assign any_hit = |hit_vec;

endmodule

// ----- design/ip_allow_deny_list_classifier_core.sv -----
`timescale 1ns / 1ps

// IPv4 allow/deny classifier. One transaction is in work at a time. A check
// runs the hash pipeline of two multiplies, then one registered table read per
// list, and skips the deny read on an allow hit. Expire sweep and clear by
// source walk the whole slot table of both lists, reading and then evaluating
// each slot; clear all invalidates the whole table slot by slot. After reset a
// clearing pass over the whole table runs before in_ready rises. Prefixes live
// in a row of cells that all compare in parallel, so their count does not
// change the timing.
module ip_allow_deny_list_classifier_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  iadc_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output iadc_pkg::rsp_t  out_data
);

  localparam int AW = iadc_pkg::SLOT_AW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_H2   = 4'd2;
  localparam logic [3:0] S_RD0  = 4'd3;
  localparam logic [3:0] S_EV0  = 4'd4;
  localparam logic [3:0] S_RD1  = 4'd5;
  localparam logic [3:0] S_EV1  = 4'd6;
  localparam logic [3:0] S_PFX  = 4'd7;
  localparam logic [3:0] S_SWR  = 4'd8;
  localparam logic [3:0] S_SWE  = 4'd9;
  localparam logic [3:0] S_CLR  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  iadc_pkg::req_t   req_r;
  logic [3:0]       state_r, state_nxt;
  logic [AW-1:0]    sweep_r, sweep_nxt;
  logic [AW-1:0]    slot_addr_r, slot_addr_nxt;
  logic [iadc_pkg::CNT_W-1:0]   cnt_r [2];
  logic [iadc_pkg::CNT_W-1:0]   cnt_nxt [2];
  logic [iadc_pkg::FILL_W-1:0]  fill_r [2];
  logic [iadc_pkg::FILL_W-1:0]  fill_nxt [2];
  logic [63:0]      hits_r [2];
  logic [63:0]      hits_nxt [2];
  logic [63:0]      vcnt_r [2];
  logic [63:0]      vcnt_nxt [2];
  logic [1:0]       res_verdict_r, res_verdict_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic [iadc_pkg::SWEPT_W-1:0] res_swept_r, res_swept_nxt;
  logic             clr_done_r, clr_done_nxt;
  logic             out_valid_r, out_valid_nxt;
  iadc_pkg::rsp_t   out_data_r, out_data_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  iadc_pkg::slot_t               ram_wdata, ram_rdata;
  logic [iadc_pkg::HASH_BITS-1:0] hash_idx;
  iadc_pkg::pfx_ctl_t            pfx_ctl [2];
  iadc_pkg::pfx_ent_t            pfx_new;
  iadc_pkg::pfx_query_t          pfx_query;
  logic [1:0]                    pfx_any;
  logic [31:0]                   deadline;
  logic [63:0]                   stat_sel;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Deadline stored by adds; a wrapped sum of zero never expires
  assign deadline = (req_r.expire_seconds != 32'd0) ?
                    (req_r.now_time + req_r.expire_seconds) : 32'd0;

  assign pfx_new   = '{net: req_r.address, len: req_r.mask_len, deadline: deadline};
  assign pfx_query = '{addr: req_r.address, plen: req_r.mask_len,
                       now: req_r.now_time,
                       exact_cmp: (req_r.req_type == iadc_pkg::OP_RM_PFX)};

  // Slot table of both lists
  iadc_ram #(
    .WIDTH ($bits(iadc_pkg::slot_t)),
    .DEPTH (iadc_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  iadc_hash u_hash (
    .clk      (clk),
    .addr     (req_r.address),
    .slot_idx (hash_idx)
  );

  for (genvar l = 0; l < 2; l++) begin : g_list
    iadc_chain u_chain (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (pfx_ctl[l]),
      .fill    (fill_r[l]),
      .new_ent (pfx_new),
      .query   (pfx_query),
      .any_hit (pfx_any[l])
    );
  end

  // Statistic selection
  always_comb begin
    stat_sel = 64'd0;
    if (req_r.req_type == iadc_pkg::OP_STAT) begin
      unique case (req_r.stat_index)
        iadc_pkg::STAT_ALLOW_CNT:  stat_sel = 64'(cnt_r[0]);
        iadc_pkg::STAT_DENY_CNT:   stat_sel = 64'(cnt_r[1]);
        iadc_pkg::STAT_ALLOW_FILL: stat_sel = 64'(fill_r[0]);
        iadc_pkg::STAT_DENY_FILL:  stat_sel = 64'(fill_r[1]);
        iadc_pkg::STAT_ALLOW_HITS: stat_sel = hits_r[0];
        iadc_pkg::STAT_DENY_HITS:  stat_sel = hits_r[1];
        iadc_pkg::STAT_BYPASSES:   stat_sel = vcnt_r[0];
        iadc_pkg::STAT_DROPS:      stat_sel = vcnt_r[1];
        default:                   stat_sel = 64'd0;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    logic cur_list;
    logic slot_match;
    logic slot_exp;
    logic hit_l;
    logic sweep_hit;
    logic pl;

    cur_list   = slot_addr_r[AW-1];
    slot_match = ram_rdata.valid && (ram_rdata.key == req_r.address);
    slot_exp   = iadc_pkg::expired(ram_rdata.deadline, req_r.now_time);
    hit_l      = 1'b0;
    sweep_hit  = 1'b0;
    pl         = req_r.list_sel;

    state_nxt       = state_r;
    sweep_nxt       = sweep_r;
    slot_addr_nxt   = slot_addr_r;
    cnt_nxt         = cnt_r;
    fill_nxt        = fill_r;
    hits_nxt        = hits_r;
    vcnt_nxt        = vcnt_r;
    res_verdict_nxt = res_verdict_r;
    res_ok_nxt      = res_ok_r;
    res_swept_nxt   = res_swept_r;
    clr_done_nxt    = clr_done_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;

    ram_we          = 1'b0;
    ram_waddr       = slot_addr_r;
    ram_raddr       = sweep_r;
    ram_wdata       = ram_rdata;
    ram_wdata.valid = 1'b0;
    pfx_ctl[0]      = '0;
    pfx_ctl[1]      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        res_verdict_nxt = iadc_pkg::VERDICT_NEUTRAL;
        res_ok_nxt      = 1'b0;
        res_swept_nxt   = '0;
        case (req_r.req_type) inside
          iadc_pkg::OP_CHECK, iadc_pkg::OP_ADD_ADDR, iadc_pkg::OP_RM_ADDR: begin
            state_nxt = S_H2;
          end
          iadc_pkg::OP_ADD_PFX, iadc_pkg::OP_RM_PFX: begin
            state_nxt = S_PFX;
          end
          iadc_pkg::OP_SWEEP, iadc_pkg::OP_CLR_SRC: begin
            sweep_nxt = '0;
            state_nxt = S_SWR;
          end
          iadc_pkg::OP_CLEAR_ALL: begin
            fill_nxt[0]  = '0;
            fill_nxt[1]  = '0;
            cnt_nxt[0]   = '0;
            cnt_nxt[1]   = '0;
            sweep_nxt    = '0;
            clr_done_nxt = 1'b1;
            state_nxt    = S_CLR;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_H2: begin
        state_nxt = S_RD0;
      end

      S_RD0, S_RD1: begin
        if (state_r == S_RD1) begin
          ram_raddr = {1'b1, hash_idx};
          state_nxt = S_EV1;
        end else begin
          ram_raddr = {((req_r.req_type == iadc_pkg::OP_CHECK) ? 1'b0 : req_r.list_sel),
                       hash_idx};
          state_nxt = S_EV0;
        end
        slot_addr_nxt = ram_raddr;
      end

      S_EV0, S_EV1: begin
        state_nxt = S_DONE;
        case (req_r.req_type)
          iadc_pkg::OP_CHECK: begin
            // Expired exact entry is freed on the way
            if (slot_match && slot_exp) begin
              ram_we = 1'b1;
              if (cnt_r[cur_list] != '0) begin
                cnt_nxt[cur_list] = cnt_r[cur_list] - 1'b1;
              end
            end
            hit_l = (slot_match && !slot_exp) || pfx_any[cur_list];
            if (hit_l) begin
              hits_nxt[cur_list] = hits_r[cur_list] + 64'd1;
              vcnt_nxt[cur_list] = vcnt_r[cur_list] + 64'd1;
              res_verdict_nxt    = cur_list ? iadc_pkg::VERDICT_DROP
                                            : iadc_pkg::VERDICT_BYPASS;
            end else if (state_r == S_EV0) begin
              state_nxt = S_RD1;
            end
          end
          iadc_pkg::OP_ADD_ADDR: begin
            if (!ram_rdata.valid) begin
              cnt_nxt[cur_list] = cnt_r[cur_list] + 1'b1;
            end
            ram_we     = 1'b1;
            ram_wdata  = '{key: req_r.address, deadline: deadline, valid: 1'b1,
                           src: req_r.source_code};
            res_ok_nxt = 1'b1;
          end
          iadc_pkg::OP_RM_ADDR: begin
            if (slot_match) begin
              ram_we = 1'b1;
              if (cnt_r[cur_list] != '0) begin
                cnt_nxt[cur_list] = cnt_r[cur_list] - 1'b1;
              end
              res_ok_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      S_PFX: begin
        state_nxt = S_DONE;
        if (req_r.req_type == iadc_pkg::OP_ADD_PFX) begin
          if (fill_r[pl] < iadc_pkg::FILL_W'(iadc_pkg::RANGE_DEPTH)) begin
            pfx_ctl[pl].add = 1'b1;
            fill_nxt[pl]    = fill_r[pl] + 1'b1;
            res_ok_nxt      = 1'b1;
          end
        end else if (pfx_any[pl]) begin
          pfx_ctl[pl].del = 1'b1;
          fill_nxt[pl]    = fill_r[pl] - 1'b1;
          res_ok_nxt      = 1'b1;
        end
      end

      S_SWR: begin
        ram_raddr = sweep_r;
        state_nxt = S_SWE;
      end

      S_SWE: begin
        ram_waddr = sweep_r;
        if (req_r.req_type == iadc_pkg::OP_SWEEP) begin
          sweep_hit = ram_rdata.valid && slot_exp;
        end else begin
          sweep_hit = ram_rdata.valid && (ram_rdata.src == req_r.source_code);
        end
        if (sweep_hit) begin
          ram_we = 1'b1;
          if (cnt_r[sweep_r[AW-1]] != '0) begin
            cnt_nxt[sweep_r[AW-1]] = cnt_r[sweep_r[AW-1]] - 1'b1;
          end
          res_swept_nxt = res_swept_r + 1'b1;
        end
        if (sweep_r == {AW{1'b1}}) begin
          state_nxt = S_DONE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
          state_nxt = S_SWR;
        end
      end

      S_CLR: begin
        // Invalidate one slot a cycle
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = '0;
        if (sweep_r == {AW{1'b1}}) begin
          state_nxt    = clr_done_r ? S_DONE : S_IDLE;
          clr_done_nxt = 1'b0;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{verdict: res_verdict_r, op_ok: res_ok_r,
                            swept_count: 14'(res_swept_r), stat_value: stat_sel};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    slot_addr_r   <= slot_addr_nxt;
    res_verdict_r <= res_verdict_nxt;
    res_ok_r      <= res_ok_nxt;
    res_swept_r   <= res_swept_nxt;
    out_data_r    <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_CLR;
      sweep_r     <= '0;
      clr_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < 2; l++) begin
        cnt_r[l]  <= '0;
        fill_r[l] <= '0;
        hits_r[l] <= '0;
        vcnt_r[l] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      clr_done_r  <= clr_done_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      hits_r      <= hits_nxt;
      vcnt_r      <= vcnt_nxt;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= iadc_pkg::FILL_W'(iadc_pkg::RANGE_DEPTH)) &&
    (fill_r[1] <= iadc_pkg::FILL_W'(iadc_pkg::RANGE_DEPTH)))
    else $error("prefix fill above depth");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISP))
    else $error("accepted transaction not dispatched");

endmodule
